// ===== hw/rtl/sbl_pkg.sv =====
// ----------------------------------------------------------------------------
// sbl_pkg: shared types and constants of the sorted byte list
// Request and result payloads, the wave record that moves along the cell
// row, request mode codes and the default capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package sbl_pkg;

  localparam int CAPACITY = 16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] value;
  } request_t;

  typedef struct packed {
    logic       success;
    logic [7:0] removed_value;
    logic [4:0] entry_count;
    logic       list_empty;
  } result_t;

  // One request in flight along the cell row. For an insert, flag means a
  // value is still carried and value is that value. For a delete, flag means
  // the match has been found and value is the byte searched for.
  typedef struct packed {
    logic       active;
    logic       mode;
    logic       flag;
    logic [7:0] value;
  } wave_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbl_cell.sv =====
// ----------------------------------------------------------------------------
// sbl_cell: one slot of the sorted byte list
// Holds one entry and passes the request wave to its right neighbor each
// cycle, swapping in an inserted value or pulling the neighbor's entry left
// on a delete.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [CW-1:0]  count,
  input  wire sbl_pkg::wave_t wave_in,
  input  wire logic [7:0]     right_entry,
  output logic [7:0]          entry,
  output sbl_pkg::wave_t      wave_out
);

  logic [7:0]     entry_next;
  sbl_pkg::wave_t wave_next;
  logic           occupied;

  assign occupied = CW'(IDX) < count;

  always_comb begin
    entry_next = entry;
    wave_next  = wave_in;
    if (wave_in.active) begin
      if (wave_in.mode == sbl_pkg::MODE_INSERT) begin
        if (wave_in.flag) begin
          if (!occupied) begin
            entry_next     = wave_in.value;
            wave_next.flag = 1'b0;
          end else if (entry >= wave_in.value) begin
            // Displace the stored entry; it rides on to the next slot.
            entry_next      = wave_in.value;
            wave_next.value = entry;
          end
        end
      end else begin
        if (wave_in.flag) begin
          entry_next = right_entry;
        end else if (occupied && (entry == wave_in.value)) begin
          entry_next     = right_entry;
          wave_next.flag = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      wave_out.active <= 1'b0;
    end else begin
      wave_out <= wave_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbl_ctrl: request launch, entry count and result register
// Starts a wave at the head of the cell row, tracks the entry count and
// builds the result when the wave leaves the last cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_ctrl #(
  parameter int CAPACITY = sbl_pkg::CAPACITY,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire sbl_pkg::request_t request,
  input  wire sbl_pkg::wave_t    exit_wave,
  output logic                   busy,
  output logic [CW-1:0]          count,
  output sbl_pkg::wave_t         launch,
  output logic                   done,
  output sbl_pkg::result_t       result
);

  logic          accept;
  logic          ins_ok;
  logic          success;
  logic [CW-1:0] count_next;

  assign accept = start && !busy;

  always_comb begin
    launch.active = accept;
    launch.mode   = request.mode;
    launch.value  = request.value;
    if (request.mode == sbl_pkg::MODE_INSERT) begin
      launch.flag = count < CW'(CAPACITY);
    end else begin
      launch.flag = 1'b0;
    end
  end

  always_comb begin
    if (exit_wave.mode == sbl_pkg::MODE_INSERT) begin
      success = ins_ok;
    end else begin
      success = exit_wave.flag;
    end
    count_next = count;
    if (success) begin
      if (exit_wave.mode == sbl_pkg::MODE_INSERT) begin
        count_next = count + CW'(1);
      end else begin
        count_next = count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        busy   <= 1'b1;
        ins_ok <= launch.flag;
      end
      if (exit_wave.active) begin
        busy  <= 1'b0;
        done  <= 1'b1;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exit_wave.active) begin
      result.success       <= success;
      result.removed_value <= (success && (exit_wave.mode == sbl_pkg::MODE_DELETE))
                              ? exit_wave.value : 8'd0;
      result.entry_count   <= 5'(count_next);
      result.list_empty    <= count_next == '0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_byte_list.sv =====
// ----------------------------------------------------------------------------
// sorted_byte_list: bounded list of bytes kept in ascending unsigned order
// A row of CAPACITY cells holds the entries; each request moves along the
// row as a wave, one cell per cycle.
// ----------------------------------------------------------------------------
// Usage: a request (mode, value) is taken at a clock edge where start is
// high and busy is low. Mode insert places the value before the first entry
// that is greater or equal; it fails when the list is full. Mode delete
// removes the first equal entry and reports whether one was found.
// Exactly one result follows each request: done is high for one cycle with
// result valid, and that transfer cannot be held off by the receiver.
// Done rises once the wave has passed the register of every cell and the
// control has registered the result. Busy drops in that same cycle, so a
// new request can be taken at the edge that ends it; none is taken while
// busy. The wave walks the full cell row before the result is known.
// Reset empties the list at once and drops busy and done; the stored bytes
// themselves are not cleared since only slots below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_byte_list #(
  parameter int CAPACITY = sbl_pkg::CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire sbl_pkg::request_t request,
  output logic                   busy,
  output logic                   done,
  output sbl_pkg::result_t       result
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]  count;
  sbl_pkg::wave_t wave [CAPACITY+1];
  logic [7:0]     entries [CAPACITY];

  sbl_ctrl #(
    .CAPACITY(CAPACITY),
    .CW      (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .exit_wave(wave[CAPACITY]),
    .busy     (busy),
    .count    (count),
    .launch   (wave[0]),
    .done     (done),
    .result   (result)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [7:0] right_entry;

    // The last slot has no neighbor; what it pulls in lies beyond the count.
    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    sbl_cell #(
      .CW (CW),
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .count      (count),
      .wave_in    (wave[i]),
      .right_entry(right_entry),
      .entry      (entries[i]),
      .wave_out   (wave[i+1])
    );
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbl_checker.sv =====
// ----------------------------------------------------------------------------
// sbl_checker: port-level checks of the sorted byte list
// Watches the request and result handshakes of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire sbl_pkg::request_t request,
  input wire logic              busy,
  input wire logic              done,
  input wire sbl_pkg::result_t  result
);

  logic accept;
  assign accept = start && !busy && (request.mode || !request.mode);

  // A taken request keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("busy or done wrong right after a request transfer");

  // Busy ends exactly when the result transfer is shown.
  a_fall_with_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy dropped without a result transfer");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result transfer while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result transfer longer than one cycle");

  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.success) |-> (result.removed_value == 8'd0))
    else $error("failed request reports a removed byte");

endmodule

bind sorted_byte_list sbl_checker u_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted byte list
// Drives insert and delete requests through the start/busy handshake, keeps
// its own copy of the ordered list to predict every result, and compares
// each done strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb;

  localparam int STALL_LIMIT = 2000;

  class byte_list_scoreboard;
    logic [7:0]       stored_bytes[$];
    sbl_pkg::result_t pending_results[$];
    int               errors = 0;

    // Applies an accepted request to the shadow list and queues its result.
    function void note_request(sbl_pkg::request_t req);
      sbl_pkg::result_t exp;
      int               pos;
      exp = '0;
      pos = 0;
      if (req.mode == sbl_pkg::MODE_INSERT) begin
        if (stored_bytes.size() < sbl_pkg::CAPACITY) begin
          // Duplicates land in front of the equal entries already stored.
          while (pos < stored_bytes.size() && stored_bytes[pos] < req.value) pos++;
          stored_bytes.insert(pos, req.value);
          exp.success = 1'b1;
        end
      end else begin
        while (pos < stored_bytes.size() && stored_bytes[pos] != req.value) pos++;
        if (pos < stored_bytes.size()) begin
          stored_bytes.delete(pos);
          exp.success       = 1'b1;
          exp.removed_value = req.value;
        end
      end
      exp.entry_count = 5'(stored_bytes.size());
      exp.list_empty  = (stored_bytes.size() == 0);
      pending_results.push_back(exp);
    endfunction

    function void check_result(sbl_pkg::result_t got);
      sbl_pkg::result_t exp;
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding: %p", got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.success !== exp.success) begin
        $error("success: expected %0d, got %0d", exp.success, got.success);
        errors++;
      end
      if (got.removed_value !== exp.removed_value) begin
        $error("removed_value: expected %0d, got %0d", exp.removed_value, got.removed_value);
        errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
        errors++;
      end
      if (got.list_empty !== exp.list_empty) begin
        $error("list_empty: expected %0d, got %0d", exp.list_empty, got.list_empty);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  sbl_pkg::request_t request = '0;
  logic              busy;
  logic              done;
  sbl_pkg::result_t  result;

  byte_list_scoreboard sb = new();
  int sender_idle_pct = 0;
  int stall_cycles = 0;

  sorted_byte_list i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input logic req_mode, input logic [7:0] req_value);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(24, 1)) @(negedge clk);
    end
    start   <= 1'b1;
    request <= {req_mode, req_value};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      // A result leaves in the same cycle that the next request may be taken,
      // so the result is checked before the new request is noted.
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_request(request);
      if (done || (start && !busy)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("sorted_byte_list: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] fill_values [12];
    int         idle_table [3];
    int         bias_choices [3];
    int         insert_bias;
    logic [7:0] pick;
    fill_values  = '{8'd255, 8'd1, 8'd127, 8'd129, 8'd64, 8'd200,
                     8'd2, 8'd254, 8'd128, 8'd3, 8'd100, 8'd170};
    idle_table   = '{25, 47, 0};
    bias_choices = '{85, 50, 15};
    insert_bias  = 50;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: empty list, zero byte, duplicates, misses, full list.
    sender_idle_pct = 25;
    send_request(sbl_pkg::MODE_DELETE, 8'd5);
    send_request(sbl_pkg::MODE_DELETE, 8'd0);
    send_request(sbl_pkg::MODE_INSERT, 8'd0);
    send_request(sbl_pkg::MODE_DELETE, 8'd0);
    send_request(sbl_pkg::MODE_INSERT, 8'd255);
    send_request(sbl_pkg::MODE_INSERT, 8'd128);
    send_request(sbl_pkg::MODE_INSERT, 8'd128);
    send_request(sbl_pkg::MODE_DELETE, 8'd7);
    send_request(sbl_pkg::MODE_INSERT, 8'd0);
    foreach (fill_values[k]) send_request(sbl_pkg::MODE_INSERT, fill_values[k]);
    send_request(sbl_pkg::MODE_INSERT, 8'd9);
    send_request(sbl_pkg::MODE_DELETE, 8'd255);
    send_request(sbl_pkg::MODE_DELETE, 8'd0);
    send_request(sbl_pkg::MODE_DELETE, 8'd128);

    // Random part: the insert bias is redrawn every 40 requests so the fill
    // level sweeps between empty and full; most deletes target a stored byte.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_table[phase];
      for (int n = 0; n < 567; n++) begin
        if (n % 40 == 0) insert_bias = bias_choices[$urandom_range(2)];
        if ($urandom_range(99) < insert_bias) begin
          pick = ($urandom_range(3) == 0) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
          send_request(sbl_pkg::MODE_INSERT, pick);
        end else begin
          if (sb.stored_bytes.size() != 0 && $urandom_range(99) < 70)
            pick = sb.stored_bytes[$urandom_range(sb.stored_bytes.size() - 1)];
          else
            pick = 8'($urandom_range(255));
          send_request(sbl_pkg::MODE_DELETE, pick);
        end
      end
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (sbl_pkg::CAPACITY + 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("sorted_byte_list: match");
    end else begin
      $display("sorted_byte_list: mismatch");
    end
    $finish;
  end

endmodule
